/* rtl/sbfp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package sbfp_pkg;

    // Pool geometry
    localparam int SUPERBLOCK_BYTES = 8192;
    localparam int HEADER_BYTES     = 16;
    localparam int MAX_BLOCKS       = 256;
    localparam int HDR_SHIFT        = $clog2(HEADER_BYTES);
    localparam int UNITS            = SUPERBLOCK_BYTES / HEADER_BYTES;

    // Field widths
    localparam int SIZE_W     = 13;
    localparam int IDX_W      = 8;
    localparam int STATUS_W   = 2;
    localparam int OFFSET_W   = 13;
    localparam int CNT_W      = 9;
    localparam int UBYTES_W   = 14;
    localparam int PCT_W      = 7;

    // Internal widths
    localparam int ADDR_W     = $clog2(MAX_BLOCKS);
    localparam int LINK_W     = $clog2(MAX_BLOCKS + 1);
    localparam int PITCH_W    =
        $clog2((((1 << SIZE_W) - 1 + 2 * HEADER_BYTES - 1) / HEADER_BYTES) + 1);

    // Percent scaling and divider sizing
    localparam int PCT_SCALE  = 100;
    localparam int PCT_MULT_W = $clog2(PCT_SCALE + 1);
    localparam int DVD_W      = $clog2(PCT_SCALE * MAX_BLOCKS + 1);
    localparam int QUO_RAW_W  = $clog2(UNITS + 1);
    localparam int QUO_W      = ((QUO_RAW_W + 1) / 2) * 2;
    localparam int DIV_STEPS  = QUO_W / 2;
    localparam int DCNT_W     = $clog2(DIV_STEPS + 1);
    localparam int SH_W       = PITCH_W + QUO_W - 1;

    // Pool after reset
    localparam int RESET_SIZE  = 16;
    localparam int RESET_PITCH = (RESET_SIZE + 2 * HEADER_BYTES - 1) / HEADER_BYTES;
    localparam int RESET_RAW   = UNITS / RESET_PITCH;
    localparam int RESET_TOTAL = (RESET_RAW > MAX_BLOCKS) ? MAX_BLOCKS : RESET_RAW;

    // Request action codes
    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK,
        STATUS_EMPTY,
        STATUS_FULL,
        STATUS_BAD_INDEX
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CFG_DIV,
        ST_READ,
        ST_CALC,
        ST_DIV,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [LINK_W-1:0] wr_data;
        logic              clear;
    } link_req_t;

    typedef struct packed {
        logic               start;
        logic [DVD_W-1:0]   dividend;
        logic [PITCH_W-1:0] divisor;
    } div_req_t;

endpackage

`default_nettype wire

/* rtl/superblock_free_block_pool.sv */
// Superblock free-block pool: a LIFO free stack of equal blocks, linked
// through a next-link memory of one entry per block.
// Request channel (s_valid/s_ready): s_action 0 allocates the top block,
// 1 frees s_block_index. Every request gives one result on the m_ channel
// (m_valid/m_ready) with status, popped index and byte offset, free and
// total counts, used bytes and the used percentage.
// Configuration channel (cfg_valid/cfg_ready): cfg_data sets the payload
// size per block and rebuilds the stack with block 0 on top; the block
// count is worked out by the shared divider, and while it runs no request is
// taken.
// Each request pops or pushes against the link memory read (READ), forms the
// offset and used bytes (CALC), runs the 2-bit-a-cycle divider for the
// percentage (DIV) and loads the output register (DONE); a new request is
// taken only after that, back in IDLE.
// Reset (aresetn low, synchronous) restores the pool for a 16-byte size
// with every block free. A stalled receiver holds the result in the output
// register; the next request finishes its work and waits there until the
// output register frees.
`timescale 1ns / 1ps
`default_nettype none

module superblock_free_block_pool (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,

    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [sbfp_pkg::SIZE_W-1:0]   cfg_data,

    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_action,
    input  wire logic [sbfp_pkg::IDX_W-1:0]    s_block_index,

    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [sbfp_pkg::STATUS_W-1:0]      m_status,
    output logic [sbfp_pkg::IDX_W-1:0]         m_alloc_index,
    output logic [sbfp_pkg::OFFSET_W-1:0]      m_alloc_offset,
    output logic [sbfp_pkg::CNT_W-1:0]         m_free_blocks,
    output logic [sbfp_pkg::CNT_W-1:0]         m_total_blocks,
    output logic [sbfp_pkg::UBYTES_W-1:0]      m_used_bytes,
    output logic [sbfp_pkg::PCT_W-1:0]         m_fullness_percent
);
    import sbfp_pkg::*;

    state_t state_reg, state_next;

    logic [LINK_W-1:0]   top_reg, top_next;
    logic [CNT_W-1:0]    fc_reg, fc_next;
    logic [CNT_W-1:0]    total_reg;
    logic [PITCH_W-1:0]  pitch_reg;

    logic                action_reg;
    logic [IDX_W-1:0]    idx_reg;
    status_t             status_reg, status_next;
    logic [LINK_W-1:0]   got_reg, got_next;
    logic [OFFSET_W-1:0] off_reg;
    logic [UBYTES_W-1:0] ub_reg;

    logic                m_valid_reg;
    status_t             m_status_reg;
    logic [IDX_W-1:0]    m_index_reg;
    logic [OFFSET_W-1:0] m_offset_reg;
    logic [CNT_W-1:0]    m_free_reg;
    logic [CNT_W-1:0]    m_total_reg;
    logic [UBYTES_W-1:0] m_ub_reg;
    logic [PCT_W-1:0]    m_pct_reg;

    logic                cfg_fire;
    logic                s_fire;
    logic                out_free;
    logic                cfg_done;
    logic                do_update;
    logic                do_calc;
    logic                out_load;
    logic                push_ok;

    logic [SIZE_W:0]                size_sum;
    logic [PITCH_W-1:0]             pitch_calc;
    logic [CNT_W-1:0]               used;
    logic [LINK_W+PITCH_W-1:0]      prod_off;
    logic [CNT_W+PITCH_W-1:0]       prod_used;
    logic [CNT_W+PCT_MULT_W-1:0]    pct_dvd;
    logic [OFFSET_W+HDR_SHIFT-1:0]  off_full;
    logic [UBYTES_W+HDR_SHIFT-1:0]  ub_full;
    logic [CNT_W-1:0]               total_calc;

    link_req_t           link_req;
    logic [LINK_W-1:0]   link;
    div_req_t            div_req;
    logic                div_busy;
    logic [QUO_W-1:0]    div_quo;

    sbfp_link_mem u_link_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (link_req),
        .rd_link (link)
    );

    sbfp_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (cfg_valid) begin
                    state_next = ST_CFG_DIV;
                end else if (s_valid) begin
                    state_next = ST_READ;
                end
            end
            ST_CFG_DIV: begin
                if (!div_busy) begin
                    state_next = ST_IDLE;
                end
            end
            ST_READ: state_next = ST_CALC;
            ST_CALC: state_next = ST_DIV;
            ST_DIV: begin
                if (!div_busy) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        cfg_ready = 1'b0;
        s_ready   = 1'b0;
        cfg_done  = 1'b0;
        do_update = 1'b0;
        do_calc   = 1'b0;
        out_load  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                cfg_ready = 1'b1;
                s_ready   = !cfg_valid;
            end
            ST_CFG_DIV: cfg_done  = !div_busy;
            ST_READ:    do_update = 1'b1;
            ST_CALC:    do_calc   = 1'b1;
            ST_DIV:     ;
            ST_DONE:    out_load  = out_free;
            default:    ;
        endcase
    end

    assign cfg_fire = cfg_valid && cfg_ready;
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    // Pitch in header units from the written size
    assign size_sum   = {1'b0, cfg_data} + (SIZE_W + 1)'(2 * HEADER_BYTES - 1);
    assign pitch_calc = size_sum[HDR_SHIFT +: PITCH_W];

    // Cap the block count
    assign total_calc = (div_quo > QUO_W'(MAX_BLOCKS)) ? CNT_W'(MAX_BLOCKS)
                                                        : div_quo[CNT_W-1:0];

    // Pop or push against the link read for the current top
    always_comb begin
        status_next = STATUS_OK;
        got_next    = '0;
        top_next    = top_reg;
        fc_next     = fc_reg;
        push_ok     = 1'b0;
        case (action_reg)
            ACT_ALLOC: begin
                if (fc_reg == '0) begin
                    status_next = STATUS_EMPTY;
                end else begin
                    got_next = top_reg;
                    top_next = (top_reg < LINK_W'(MAX_BLOCKS)) ? link : '0;
                    fc_next  = fc_reg - CNT_W'(1);
                end
            end
            ACT_FREE: begin
                if ({{(CNT_W - IDX_W){1'b0}}, idx_reg} >= total_reg) begin
                    status_next = STATUS_BAD_INDEX;
                end else if (fc_reg >= total_reg) begin
                    status_next = STATUS_FULL;
                end else begin
                    push_ok  = 1'b1;
                    top_next = {{(LINK_W - IDX_W){1'b0}}, idx_reg};
                    fc_next  = fc_reg + CNT_W'(1);
                end
            end
            default: ;
        endcase
    end

    // Offsets, used bytes and percent dividend
    always_comb begin
        used      = total_reg - fc_reg;
        prod_off  = got_reg * pitch_reg;
        prod_used = used * pitch_reg;
        pct_dvd   = used * PCT_MULT_W'(PCT_SCALE);
        off_full  = {prod_off[OFFSET_W-1:0], {HDR_SHIFT{1'b0}}};
        ub_full   = {prod_used[UBYTES_W-1:0], {HDR_SHIFT{1'b0}}};
    end

    // Link memory requests
    always_comb begin
        link_req.rd_en   = s_fire;
        link_req.rd_addr = top_reg[ADDR_W-1:0];
        link_req.wr_en   = do_update && push_ok;
        link_req.wr_addr = idx_reg[ADDR_W-1:0];
        link_req.wr_data = top_reg;
        link_req.clear   = cfg_fire;
    end

    // Divider requests: block count on rebuild, percent per request
    always_comb begin
        div_req.start = cfg_fire || do_calc;
        if (cfg_fire) begin
            div_req.dividend = DVD_W'(UNITS);
            div_req.divisor  = pitch_calc;
        end else begin
            div_req.dividend = pct_dvd[DVD_W-1:0];
            div_req.divisor  = {{(PITCH_W - CNT_W){1'b0}}, total_reg};
        end
    end

    // Control state and pool state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            top_reg     <= '0;
            fc_reg      <= CNT_W'(RESET_TOTAL);
            total_reg   <= CNT_W'(RESET_TOTAL);
            pitch_reg   <= PITCH_W'(RESET_PITCH);
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_fire) begin
                pitch_reg <= pitch_calc;
                top_reg   <= '0;
            end
            if (cfg_done) begin
                total_reg <= total_calc;
                fc_reg    <= total_calc;
            end
            if (do_update) begin
                top_reg <= top_next;
                fc_reg  <= fc_next;
            end
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Request payload and result payload
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            action_reg <= s_action;
            idx_reg    <= s_block_index;
        end
        if (do_update) begin
            status_reg <= status_next;
            got_reg    <= got_next;
        end
        if (do_calc) begin
            off_reg <= off_full[OFFSET_W-1:0];
            ub_reg  <= ub_full[UBYTES_W-1:0];
        end
        if (out_load) begin
            m_status_reg <= status_reg;
            m_index_reg  <= got_reg[IDX_W-1:0];
            m_offset_reg <= off_reg;
            m_free_reg   <= fc_reg;
            m_total_reg  <= total_reg;
            m_ub_reg     <= ub_reg;
            m_pct_reg    <= (total_reg == '0) ? '0 : div_quo[PCT_W-1:0];
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_status           = m_status_reg;
    assign m_alloc_index      = m_index_reg;
    assign m_alloc_offset     = m_offset_reg;
    assign m_free_blocks      = m_free_reg;
    assign m_total_blocks     = m_total_reg;
    assign m_used_bytes       = m_ub_reg;
    assign m_fullness_percent = m_pct_reg;

endmodule

`default_nettype wire

/* rtl/sbfp_link_mem.sv */
`timescale 1ns / 1ps
`default_nettype none

module sbfp_link_mem (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire sbfp_pkg::link_req_t       req,
    output logic [sbfp_pkg::LINK_W-1:0]    rd_link
);
    import sbfp_pkg::*;

    logic [LINK_W-1:0]     ram [MAX_BLOCKS];
    logic [MAX_BLOCKS-1:0] valid_reg;
    logic [LINK_W-1:0]     rd_data_reg;
    logic                  rd_valid_reg;
    logic [ADDR_W-1:0]     rd_addr_reg;

    // Write and read the link array, read data registered
    always_ff @(posedge aclk) begin
        if (req.wr_en) begin
            ram[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg  <= ram[req.rd_addr];
            rd_valid_reg <= valid_reg[req.rd_addr];
            rd_addr_reg  <= req.rd_addr;
        end
    end

    // Track written entries; drop them all on rebuild
    always_ff @(posedge aclk) begin
        if (!aresetn || req.clear) begin
            valid_reg <= '0;
        end else if (req.wr_en) begin
            valid_reg[req.wr_addr] <= 1'b1;
        end
    end

    // Unwritten entry links to the next block
    assign rd_link = rd_valid_reg ? rd_data_reg
                                  : ({1'b0, rd_addr_reg} + LINK_W'(1));

endmodule

`default_nettype wire

/* rtl/sbfp_div.sv */
`timescale 1ns / 1ps
`default_nettype none

module sbfp_div (
    input  wire logic                      aclk,
    input  wire logic                      aresetn,
    input  wire sbfp_pkg::div_req_t        req,
    output logic                           busy,
    output logic [sbfp_pkg::QUO_W-1:0]     quotient
);
    import sbfp_pkg::*;

    logic [SH_W-1:0]   rem_reg;
    logic [SH_W-1:0]   den_reg;
    logic [QUO_W-1:0]  quo_reg;
    logic [DCNT_W-1:0] cnt_reg;
    logic              busy_reg;

    logic              bit_hi;
    logic              bit_lo;
    logic [SH_W-1:0]   rem_mid;
    logic [SH_W-1:0]   den_half;
    logic [SH_W-1:0]   rem_end;

    // Two restoring steps per cycle
    always_comb begin
        bit_hi   = (rem_reg >= den_reg);
        rem_mid  = bit_hi ? (rem_reg - den_reg) : rem_reg;
        den_half = den_reg >> 1;
        bit_lo   = (rem_mid >= den_half);
        rem_end  = bit_lo ? (rem_mid - den_half) : rem_mid;
    end

    // Step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (req.start) begin
            busy_reg <= 1'b1;
            cnt_reg  <= DCNT_W'(DIV_STEPS);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - DCNT_W'(1);
            if (cnt_reg == DCNT_W'(1)) begin
                busy_reg <= 1'b0;
            end
        end
    end

    // Remainder, shifted divisor and quotient
    always_ff @(posedge aclk) begin
        if (req.start) begin
            rem_reg <= {{(SH_W - DVD_W){1'b0}}, req.dividend};
            den_reg <= {req.divisor, {(QUO_W - 1){1'b0}}};
            quo_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= rem_end;
            den_reg <= den_reg >> 2;
            quo_reg <= {quo_reg[QUO_W-3:0], bit_hi, bit_lo};
        end
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

/* tb/sv/tb_superblock_free_block_pool.sv */
`timescale 1ns / 1ps

module tb_superblock_free_block_pool;

    import sbfp_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int IDLE_PCT    = 12;

    // Expected content of one result beat
    typedef struct {
        status_t               status;
        logic [IDX_W-1:0]      alloc_index;
        logic [OFFSET_W-1:0]   alloc_offset;
        logic [CNT_W-1:0]      free_blocks;
        logic [CNT_W-1:0]      total_blocks;
        logic [UBYTES_W-1:0]   used_bytes;
        logic [PCT_W-1:0]      fullness_percent;
    } pool_result_t;

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  cfg_valid     = 1'b0;
    logic                  cfg_ready;
    logic [SIZE_W-1:0]     cfg_data      = '0;
    logic                  s_valid       = 1'b0;
    logic                  s_ready;
    logic                  s_action      = ACT_ALLOC;
    logic [IDX_W-1:0]      s_block_index = '0;
    logic                  m_valid;
    logic                  m_ready       = 1'b0;
    logic [STATUS_W-1:0]   m_status;
    logic [IDX_W-1:0]      m_alloc_index;
    logic [OFFSET_W-1:0]   m_alloc_offset;
    logic [CNT_W-1:0]      m_free_blocks;
    logic [CNT_W-1:0]      m_total_blocks;
    logic [UBYTES_W-1:0]   m_used_bytes;
    logic [PCT_W-1:0]      m_fullness_percent;

    // Shadow copy of the pool
    logic [LINK_W-1:0]     pool_link [0:MAX_BLOCKS-1];
    logic [LINK_W-1:0]     pool_top;
    logic [SIZE_W-1:0]     pool_size;
    int unsigned           pool_free;
    int unsigned           pool_total;
    int unsigned           pool_pitch;

    pool_result_t          pool_result_q [$];
    pool_result_t          head_res;

    int                    tx_idle_pct   = IDLE_PCT;
    int                    rx_idle_pct   = IDLE_PCT;
    int                    rx_hold_req   = 0;
    int                    rx_hold_left  = 0;
    int                    fail_count    = 0;
    int                    request_count = 0;
    int                    result_count  = 0;
    int                    size_writes   = 0;
    int                    status_seen [4] = '{0, 0, 0, 0};
    int                    cycle_count   = 0;

    superblock_free_block_pool i_dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_data           (cfg_data),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_action           (s_action),
        .s_block_index      (s_block_index),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_status           (m_status),
        .m_alloc_index      (m_alloc_index),
        .m_alloc_offset     (m_alloc_offset),
        .m_free_blocks      (m_free_blocks),
        .m_total_blocks     (m_total_blocks),
        .m_used_bytes       (m_used_bytes),
        .m_fullness_percent (m_fullness_percent)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Rebuild the free stack for a new payload size, block 0 on top
    function automatic void pool_rebuild(input logic [SIZE_W-1:0] size);
        pool_size  = size;
        pool_pitch = (size + HEADER_BYTES - 1) / HEADER_BYTES + 1;
        pool_total = (SUPERBLOCK_BYTES / HEADER_BYTES) / pool_pitch;
        if (pool_total > MAX_BLOCKS)
            pool_total = MAX_BLOCKS;
        for (int i = 0; i < MAX_BLOCKS; i++)
            pool_link[i] = LINK_W'(i + 1);
        pool_top  = '0;
        pool_free = pool_total;
    endfunction

    // Apply one request to the shadow pool and form its result
    function automatic pool_result_t pool_predict(input logic act,
                                                  input logic [IDX_W-1:0] idx);
        pool_result_t res;
        int unsigned  got;
        int unsigned  offs;
        int unsigned  used;
        int unsigned  pct;
        res.status = STATUS_OK;
        got  = 0;
        offs = 0;
        pct  = 0;
        if (act == ACT_ALLOC) begin
            if (pool_free == 0) begin
                res.status = STATUS_EMPTY;
            end else begin
                got       = pool_top;
                offs      = got * pool_pitch * HEADER_BYTES;
                pool_top  = (got < MAX_BLOCKS) ? pool_link[got] : '0;
                pool_free = pool_free - 1;
            end
        end else if (idx >= pool_total) begin
            res.status = STATUS_BAD_INDEX;
        end else if (pool_free >= pool_total) begin
            res.status = STATUS_FULL;
        end else begin
            // Push without any double-free check
            pool_link[idx] = pool_top;
            pool_top       = LINK_W'(idx);
            pool_free      = pool_free + 1;
        end
        used = pool_total - pool_free;
        if (pool_total != 0)
            pct = (100 * used) / pool_total;
        res.alloc_index      = IDX_W'(got);
        res.alloc_offset     = OFFSET_W'(offs);
        res.free_blocks      = CNT_W'(pool_free);
        res.total_blocks     = CNT_W'(pool_total);
        res.used_bytes       = UBYTES_W'(used * pool_pitch * HEADER_BYTES);
        res.fullness_percent = PCT_W'(pct);
        return res;
    endfunction

    // Bias sizes toward pools that fill and empty quickly
    function automatic logic [SIZE_W-1:0] pick_size();
        int r;
        r = $urandom_range(99);
        if (r < 30)
            return SIZE_W'($urandom_range(8191, 512));
        else if (r < 60)
            return SIZE_W'($urandom_range(511, 64));
        else if (r < 80)
            return SIZE_W'($urandom_range(63, 0));
        return SIZE_W'($urandom_range(8191, 0));
    endfunction

    task automatic check_field(input string name, input logic [31:0] expv,
                               input logic [31:0] actv);
        if (expv !== actv) begin
            $error("%s mismatch: expected %0d, got %0d", name, expv, actv);
            fail_count++;
        end
    endtask

    // Compare each accepted result with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            result_count++;
            if (pool_result_q.size() == 0) begin
                $error("result with no request outstanding");
                fail_count++;
            end else begin
                head_res = pool_result_q.pop_front();
                status_seen[head_res.status]++;
                check_field("status", head_res.status, m_status);
                check_field("alloc_index", head_res.alloc_index, m_alloc_index);
                check_field("alloc_offset", head_res.alloc_offset, m_alloc_offset);
                check_field("free_blocks", head_res.free_blocks, m_free_blocks);
                check_field("total_blocks", head_res.total_blocks, m_total_blocks);
                check_field("used_bytes", head_res.used_bytes, m_used_bytes);
                check_field("fullness_percent", head_res.fullness_percent,
                            m_fullness_percent);
            end
        end
    end

    // Drive result ready: random stalls plus requested long holds
    always @(negedge aclk) begin
        if (rx_hold_req != 0) begin
            rx_hold_left = rx_hold_req;
            rx_hold_req  = 0;
        end
        if (rx_hold_left != 0) begin
            m_ready <= 1'b0;
            rx_hold_left--;
        end else begin
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Offer one request, hold it until taken, then record its prediction
    task automatic send_request(input logic act, input logic [IDX_W-1:0] idx,
                                output pool_result_t res);
        int gap;
        gap = ($urandom_range(99) < tx_idle_pct) ? $urandom_range(4, 1) : 0;
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_action      <= act;
        s_block_index <= idx;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        res = pool_predict(act, idx);
        pool_result_q.push_back(res);
        request_count++;
    endtask

    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pool_result_q.size() != 0)
            @(posedge aclk);
    endtask

    // Write the size register once the pool is idle
    task automatic write_size(input logic [SIZE_W-1:0] size);
        drain_results();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= size;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        pool_rebuild(size);
        size_writes++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Mostly alloc/free of held blocks, with bad, full and double frees mixed in
    task automatic run_random_phase(input logic [SIZE_W-1:0] size, input int n_items,
                                    input int alloc_pct);
        logic [IDX_W-1:0] held [$];
        pool_result_t     res;
        logic [IDX_W-1:0] idx;
        int               r;
        int               k;
        write_size(size);
        repeat (n_items) begin
            r = $urandom_range(99);
            if (r < alloc_pct) begin
                send_request(ACT_ALLOC, IDX_W'($urandom_range(255)), res);
                if (res.status == STATUS_OK)
                    held.push_back(res.alloc_index);
            end else if (r < 88 && held.size() != 0) begin
                k   = $urandom_range(held.size() - 1);
                idx = held[k];
                held.delete(k);
                send_request(ACT_FREE, idx, res);
            end else begin
                if ($urandom_range(1) == 1 && pool_total != 0)
                    idx = IDX_W'($urandom_range(pool_total - 1));
                else
                    idx = IDX_W'($urandom_range(255));
                send_request(ACT_FREE, idx, res);
            end
        end
    endtask

    // Pool as left by reset: full stack, pops, double free
    task automatic test_reset_pool();
        pool_result_t res;
        send_request(ACT_FREE, 8'd0, res);
        send_request(ACT_FREE, 8'd255, res);
        repeat (3) send_request(ACT_ALLOC, 8'd255, res);
        send_request(ACT_FREE, 8'd1, res);
        send_request(ACT_FREE, 8'd1, res);
        send_request(ACT_ALLOC, 8'd0, res);
    endtask

    // Smallest and largest sizes, a one-block pool and an empty pool
    task automatic test_size_extremes();
        pool_result_t res;
        write_size(13'd0);
        send_request(ACT_ALLOC, 8'd0, res);
        send_request(ACT_FREE, 8'd255, res);
        send_request(ACT_ALLOC, 8'd0, res);
        write_size(13'd8191);
        send_request(ACT_ALLOC, 8'd0, res);
        send_request(ACT_FREE, 8'd0, res);
        send_request(ACT_FREE, 8'd255, res);
        write_size(13'd8176);
        send_request(ACT_ALLOC, 8'd0, res);
        send_request(ACT_ALLOC, 8'd0, res);
        send_request(ACT_FREE, 8'd1, res);
        send_request(ACT_FREE, 8'd0, res);
        send_request(ACT_FREE, 8'd0, res);
        write_size(13'd100);
        send_request(ACT_FREE, 8'd64, res);
        send_request(ACT_ALLOC, 8'd0, res);
        send_request(ACT_FREE, 8'd63, res);
        send_request(ACT_FREE, 8'd0, res);
    endtask

    // Hold the receiver off so the block backs up, then pause the sender
    task automatic test_backpressure();
        pool_result_t     res;
        logic [IDX_W-1:0] held [$];
        write_size(13'd200);
        tx_idle_pct = 0;
        rx_hold_req = 300;
        for (int i = 0; i < 24; i++) begin
            if (i % 3 != 2 || held.size() == 0) begin
                send_request(ACT_ALLOC, IDX_W'($urandom_range(255)), res);
                if (res.status == STATUS_OK)
                    held.push_back(res.alloc_index);
            end else begin
                send_request(ACT_FREE, held.pop_front(), res);
            end
        end
        tx_idle_pct = IDLE_PCT;
        drain_results();
        while (held.size() != 0)
            send_request(ACT_FREE, held.pop_back(), res);
    endtask

    // Back-to-back traffic with no idling on either side
    task automatic test_quiet_stretch();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_random_phase(pick_size(), 60, 50);
        tx_idle_pct = IDLE_PCT;
        rx_idle_pct = IDLE_PCT;
    endtask

    task automatic test_random_traffic();
        logic [SIZE_W-1:0] size;
        for (int ph = 0; ph < 14; ph++) begin
            case (ph)
                0:       size = 13'd0;
                1:       size = 13'd8191;
                2:       size = 13'd1;
                3:       size = 13'd4096;
                default: size = pick_size();
            endcase
            run_random_phase(size, 70, (ph % 2 == 0) ? 65 : 35);
        end
    endtask

    initial begin
        pool_rebuild(SIZE_W'(RESET_SIZE));
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_reset_pool();
        test_size_extremes();
        test_backpressure();
        test_quiet_stretch();
        test_random_traffic();

        // Let the last results come out, then idle a little longer
        drain_results();
        repeat (30) @(posedge aclk);

        $display("Covered %0d requests and %0d results over %0d size writes",
                 request_count, result_count, size_writes);
        $display("Status mix: ok %0d, empty %0d, full %0d, bad index %0d",
                 status_seen[STATUS_OK], status_seen[STATUS_EMPTY],
                 status_seen[STATUS_FULL], status_seen[STATUS_BAD_INDEX]);
        if (fail_count == 0 && pool_result_q.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
